// File: design/tatr_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package tatr_pkg;

    // default widths of the sample and coordinate fields
    localparam int DEF_ADC_BITS   = 12;
    localparam int DEF_COORD_BITS = 12;

    // screen size registers are fixed at 13 bits
    localparam int SIZE_BITS = 13;
    localparam int STEP_W    = $clog2(SIZE_BITS);

    // configuration register indexes
    localparam int CFG_IDX_BITS = 3;
    localparam logic [CFG_IDX_BITS-1:0] REG_X_AD_START    = 3'd0;
    localparam logic [CFG_IDX_BITS-1:0] REG_X_AD_END      = 3'd1;
    localparam logic [CFG_IDX_BITS-1:0] REG_Y_AD_START    = 3'd2;
    localparam logic [CFG_IDX_BITS-1:0] REG_Y_AD_END      = 3'd3;
    localparam logic [CFG_IDX_BITS-1:0] REG_SWAP_AXES     = 3'd4;
    localparam logic [CFG_IDX_BITS-1:0] REG_SCREEN_WIDTH  = 3'd5;
    localparam logic [CFG_IDX_BITS-1:0] REG_SCREEN_HEIGHT = 3'd6;

    // configuration reset values
    localparam int RST_AD_START      = 0;
    localparam int RST_AD_END        = 4095;
    localparam int RST_SCREEN_WIDTH  = 320;
    localparam int RST_SCREEN_HEIGHT = 240;

    // queue between classifier and mapper
    localparam int QUEUE_DEPTH = 2;

    // manhattan distance that must be exceeded to report a move
    localparam int MOVE_THRESHOLD = 2;

    // mapper sequencer
    typedef enum logic [1:0] {
        BK_IDLE,
        BK_MUL,
        BK_DIV,
        BK_UPD
    } back_state_t;

endpackage

`default_nettype wire

// File: design/touch_adc_to_screen_tracker_core.sv
// the mapper handles one item at a time, in the states issue (idle), multiply,
//   13-step restoring divide with one quotient bit per axis per cycle, and update,
//   where it waits while the result register is stalled
// out-of-span items skip multiply and divide; a 2-entry queue decouples input from mapper
// reset (rst_n, async, active low): calibration registers to defaults, point at origin,
//   released, queue and result register empty
`timescale 1ns / 1ps
`default_nettype none

module touch_adc_to_screen_tracker_core
    import tatr_pkg::*;
#(
    parameter int ADC_BITS   = DEF_ADC_BITS,
    parameter int COORD_BITS = DEF_COORD_BITS
)
(
    input  wire logic                    clk,
    input  wire logic                    rst_n,
    input  wire logic                    s_tvalid,
    output logic                         s_tready,
    input  wire logic [((2*ADC_BITS+7)/8)*8-1:0]   s_tdata,  // raw_x, raw_y
    output logic                         m_tvalid,
    input  wire logic                    m_tready,
    output logic [((2+2*COORD_BITS+7)/8)*8-1:0]    m_tdata,  // pressed, pos_x, pos_y, moved
    input  wire logic                    cfg_we,
    input  wire logic [CFG_IDX_BITS-1:0] cfg_idx,
    input  wire logic [((ADC_BITS > SIZE_BITS) ? ADC_BITS : SIZE_BITS)-1:0] cfg_data
);

    localparam int IN_W   = ((2 * ADC_BITS + 7) / 8) * 8;
    localparam int OUT_W  = ((2 + 2 * COORD_BITS + 7) / 8) * 8;
    localparam int ITEM_W = 1 + 4 * ADC_BITS;

    logic [ADC_BITS-1:0]  x_start_reg;
    logic [ADC_BITS-1:0]  x_end_reg;
    logic [ADC_BITS-1:0]  y_start_reg;
    logic [ADC_BITS-1:0]  y_end_reg;
    logic                 swap_reg;
    logic [SIZE_BITS-1:0] width_reg;
    logic [SIZE_BITS-1:0] height_reg;

    logic                 push;
    logic [ITEM_W-1:0]    push_data;
    logic                 q_full;
    logic                 q_pop;
    logic [ITEM_W-1:0]    q_data;
    logic                 q_valid;

    // calibration register writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            x_start_reg <= ADC_BITS'(RST_AD_START);
            x_end_reg   <= ADC_BITS'(RST_AD_END);
            y_start_reg <= ADC_BITS'(RST_AD_START);
            y_end_reg   <= ADC_BITS'(RST_AD_END);
            swap_reg    <= 1'b0;
            width_reg   <= SIZE_BITS'(RST_SCREEN_WIDTH);
            height_reg  <= SIZE_BITS'(RST_SCREEN_HEIGHT);
        end
        else if (cfg_we)
        begin
            case (cfg_idx)
                REG_X_AD_START:    x_start_reg <= cfg_data[ADC_BITS-1:0];
                REG_X_AD_END:      x_end_reg   <= cfg_data[ADC_BITS-1:0];
                REG_Y_AD_START:    y_start_reg <= cfg_data[ADC_BITS-1:0];
                REG_Y_AD_END:      y_end_reg   <= cfg_data[ADC_BITS-1:0];
                REG_SWAP_AXES:     swap_reg    <= cfg_data[0];
                REG_SCREEN_WIDTH:  width_reg   <= cfg_data[SIZE_BITS-1:0];
                REG_SCREEN_HEIGHT: height_reg  <= cfg_data[SIZE_BITS-1:0];
                default:           swap_reg    <= swap_reg;
            endcase
        end
    end

    // classifier
    tatr_front #(
        .ADC_BITS (ADC_BITS),
        .ITEM_W   (ITEM_W),
        .IN_W     (IN_W)
    ) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .x_start   (x_start_reg),
        .x_end     (x_end_reg),
        .y_start   (y_start_reg),
        .y_end     (y_end_reg),
        .swap      (swap_reg),
        .q_full    (q_full),
        .push      (push),
        .push_data (push_data)
    );

    // queue of classified samples
    tatr_queue #(
        .WIDTH (ITEM_W),
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_data (push_data),
        .full      (q_full),
        .pop       (q_pop),
        .pop_data  (q_data),
        .not_empty (q_valid)
    );

    // mapper and tracker
    tatr_back #(
        .ADC_BITS   (ADC_BITS),
        .COORD_BITS (COORD_BITS),
        .ITEM_W     (ITEM_W),
        .OUT_W      (OUT_W)
    ) u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .q_valid    (q_valid),
        .q_pop      (q_pop),
        .q_data     (q_data),
        .width_cfg  (width_reg),
        .height_cfg (height_reg),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata)
    );

endmodule

`default_nettype wire

// File: design/tatr_front.sv
`timescale 1ns / 1ps
`default_nettype none

module tatr_front
    import tatr_pkg::*;
#(
    parameter int ADC_BITS = DEF_ADC_BITS,
    parameter int ITEM_W   = 1 + 4 * DEF_ADC_BITS,
    parameter int IN_W     = 24
)
(
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                s_tvalid,
    output logic                     s_tready,
    input  wire logic [IN_W-1:0]     s_tdata,     // raw_x, raw_y
    input  wire logic [ADC_BITS-1:0] x_start,
    input  wire logic [ADC_BITS-1:0] x_end,
    input  wire logic [ADC_BITS-1:0] y_start,
    input  wire logic [ADC_BITS-1:0] y_end,
    input  wire logic                swap,
    input  wire logic                q_full,
    output logic                     push,
    output logic [ITEM_W-1:0]        push_data
);

    logic                valid_reg;
    logic                valid_next;
    logic [ITEM_W-1:0]   item_reg;
    logic [ITEM_W-1:0]   item_next;

    logic [ADC_BITS-1:0] raw_x;
    logic [ADC_BITS-1:0] raw_y;
    logic [ADC_BITS-1:0] ax;
    logic [ADC_BITS-1:0] ay;
    logic [ADC_BITS-1:0] dx;
    logic [ADC_BITS-1:0] dy;
    logic [ADC_BITS-1:0] sx;
    logic [ADC_BITS-1:0] sy;
    logic                x_ok;
    logic                y_ok;
    logic                accept;

    assign raw_x = s_tdata[ADC_BITS-1:0];
    assign raw_y = s_tdata[2*ADC_BITS-1:ADC_BITS];

    // classify: swap, span check, distance from start and span length
    always_comb
    begin
        ax = swap ? raw_y : raw_x;
        ay = swap ? raw_x : raw_y;
        if (x_start <= x_end)
        begin
            x_ok = (ax >= x_start) && (ax <= x_end);
            sx   = x_end - x_start;
        end
        else
        begin
            x_ok = (ax >= x_end) && (ax <= x_start);
            sx   = x_start - x_end;
        end
        if (y_start <= y_end)
        begin
            y_ok = (ay >= y_start) && (ay <= y_end);
            sy   = y_end - y_start;
        end
        else
        begin
            y_ok = (ay >= y_end) && (ay <= y_start);
            sy   = y_start - y_end;
        end
        dx = (ax >= x_start) ? ax - x_start : x_start - ax;
        dy = (ay >= y_start) ? ay - y_start : y_start - ay;
    end

    // one-entry stage ahead of the queue
    assign push     = valid_reg && !q_full;
    assign s_tready = !valid_reg || !q_full;
    assign accept   = s_tvalid && s_tready;
    assign push_data = item_reg;

    always_comb
    begin
        valid_next = valid_reg;
        item_next  = item_reg;
        if (push)
        begin
            valid_next = 1'b0;
        end
        if (accept)
        begin
            valid_next = 1'b1;
            item_next  = {x_ok && y_ok, sy, dy, sx, dx};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        item_reg <= item_next;
    end

endmodule

`default_nettype wire

// File: design/tatr_queue.sv
`timescale 1ns / 1ps
`default_nettype none

module tatr_queue
    import tatr_pkg::*;
#(
    parameter int WIDTH = 1 + 4 * DEF_ADC_BITS,
    parameter int DEPTH = QUEUE_DEPTH
)
(
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             push,
    input  wire logic [WIDTH-1:0] push_data,
    output logic                  full,
    input  wire logic             pop,
    output logic [WIDTH-1:0]      pop_data,
    output logic                  not_empty
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_next;
    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;
    logic             do_push;
    logic             do_pop;

    assign full      = (count_reg == CNT_W'(DEPTH));
    assign not_empty = (count_reg != '0);
    assign do_push   = push && !full;
    assign do_pop    = pop && not_empty;
    assign pop_data  = mem_reg[rd_ptr_reg];

    // pointer and fill count update
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // entry storage
    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

`default_nettype wire

// File: design/tatr_back.sv
`timescale 1ns / 1ps
`default_nettype none

module tatr_back
    import tatr_pkg::*;
#(
    parameter int ADC_BITS   = DEF_ADC_BITS,
    parameter int COORD_BITS = DEF_COORD_BITS,
    parameter int ITEM_W     = 1 + 4 * DEF_ADC_BITS,
    parameter int OUT_W      = 32
)
(
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 q_valid,
    output logic                      q_pop,
    input  wire logic [ITEM_W-1:0]    q_data,
    input  wire logic [SIZE_BITS-1:0] width_cfg,
    input  wire logic [SIZE_BITS-1:0] height_cfg,
    output logic                      m_tvalid,
    input  wire logic                 m_tready,
    output logic [OUT_W-1:0]          m_tdata    // pressed, pos_x, pos_y, moved
);

    localparam int SB    = SIZE_BITS;
    localparam int PW    = ADC_BITS + SB;
    localparam int CW    = (SB > COORD_BITS) ? SB : COORD_BITS;
    localparam int DW    = COORD_BITS + 1;
    localparam logic [CW-1:0] COORD_MAX = CW'((1 << COORD_BITS) - 1);

    back_state_t         state_reg;
    back_state_t         state_next;
    logic                out_free;
    logic                do_update;

    // item being mapped
    logic                span_ok_reg;
    logic [ADC_BITS-1:0] dx_reg;
    logic [ADC_BITS-1:0] sx_reg;
    logic [ADC_BITS-1:0] dy_reg;
    logic [ADC_BITS-1:0] sy_reg;

    // divider state per axis: partial remainder and dividend/quotient shifter
    logic [ADC_BITS-1:0] remx_reg;
    logic [ADC_BITS-1:0] remx_next;
    logic [SB-1:0]       lox_reg;
    logic [SB-1:0]       lox_next;
    logic [ADC_BITS-1:0] remy_reg;
    logic [ADC_BITS-1:0] remy_next;
    logic [SB-1:0]       loy_reg;
    logic [SB-1:0]       loy_next;
    logic [STEP_W-1:0]   step_reg;
    logic [STEP_W-1:0]   step_next;

    // tracker state
    logic [COORD_BITS-1:0] last_x_reg;
    logic [COORD_BITS-1:0] last_x_next;
    logic [COORD_BITS-1:0] last_y_reg;
    logic [COORD_BITS-1:0] last_y_next;
    logic                  touch_reg;
    logic                  touch_next;
    logic                  moved;

    logic                  out_valid_reg;
    logic                  out_valid_next;
    logic [OUT_W-1:0]      out_data_reg;
    logic [OUT_W-1:0]      out_data_next;

    logic [SB-1:0]         mx;
    logic [SB-1:0]         my;
    logic [PW-1:0]         prod_x;
    logic [PW-1:0]         prod_y;
    logic [ADC_BITS:0]     trial_x;
    logic [ADC_BITS:0]     trial_y;
    logic [CW-1:0]         qx;
    logic [CW-1:0]         qy;
    logic [COORD_BITS-1:0] px;
    logic [COORD_BITS-1:0] py;
    logic [COORD_BITS-1:0] adx;
    logic [COORD_BITS-1:0] ady;
    logic [DW-1:0]         move_sum;

    assign out_free = !out_valid_reg || m_tready;

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            BK_IDLE:
            begin
                if (q_valid)
                begin
                    state_next = q_data[4*ADC_BITS] ? BK_MUL : BK_UPD;
                end
            end
            BK_MUL:
            begin
                state_next = BK_DIV;
            end
            BK_DIV:
            begin
                if (step_reg == STEP_W'(SB - 1))
                begin
                    state_next = BK_UPD;
                end
            end
            BK_UPD:
            begin
                if (out_free)
                begin
                    state_next = BK_IDLE;
                end
            end
            default:
            begin
                state_next = BK_IDLE;
            end
        endcase
    end

    // sequencer outputs
    always_comb
    begin
        q_pop     = 1'b0;
        do_update = 1'b0;
        case (state_reg)
            BK_IDLE:
            begin
                q_pop = q_valid;
            end
            BK_UPD:
            begin
                do_update = out_free;
            end
            default:
            begin
                q_pop     = 1'b0;
                do_update = 1'b0;
            end
        endcase
    end

    // products of distance and screen size minus one
    always_comb
    begin
        mx     = (width_cfg == '0) ? '0 : width_cfg - 1'b1;
        my     = (height_cfg == '0) ? '0 : height_cfg - 1'b1;
        prod_x = PW'(dx_reg) * PW'(mx);
        prod_y = PW'(dy_reg) * PW'(my);
    end

    // restoring divide, one quotient bit per axis per cycle
    always_comb
    begin
        remx_next = remx_reg;
        lox_next  = lox_reg;
        remy_next = remy_reg;
        loy_next  = loy_reg;
        step_next = step_reg;
        trial_x   = {remx_reg, lox_reg[SB-1]};
        trial_y   = {remy_reg, loy_reg[SB-1]};
        if (state_reg == BK_MUL)
        begin
            remx_next = prod_x[PW-1:SB];
            lox_next  = prod_x[SB-1:0];
            remy_next = prod_y[PW-1:SB];
            loy_next  = prod_y[SB-1:0];
            step_next = '0;
        end
        else if (state_reg == BK_DIV)
        begin
            step_next = step_reg + 1'b1;
            if (trial_x >= {1'b0, sx_reg})
            begin
                remx_next = ADC_BITS'(trial_x - {1'b0, sx_reg});
                lox_next  = {lox_reg[SB-2:0], 1'b1};
            end
            else
            begin
                remx_next = trial_x[ADC_BITS-1:0];
                lox_next  = {lox_reg[SB-2:0], 1'b0};
            end
            if (trial_y >= {1'b0, sy_reg})
            begin
                remy_next = ADC_BITS'(trial_y - {1'b0, sy_reg});
                loy_next  = {loy_reg[SB-2:0], 1'b1};
            end
            else
            begin
                remy_next = trial_y[ADC_BITS-1:0];
                loy_next  = {loy_reg[SB-2:0], 1'b0};
            end
        end
    end

    // zero span maps to 0, large quotients saturate
    always_comb
    begin
        qx  = (sx_reg == '0) ? '0 : CW'(lox_reg);
        qy  = (sy_reg == '0) ? '0 : CW'(loy_reg);
        px  = (qx > COORD_MAX) ? '1 : qx[COORD_BITS-1:0];
        py  = (qy > COORD_MAX) ? '1 : qy[COORD_BITS-1:0];
        adx = (px > last_x_reg) ? px - last_x_reg : last_x_reg - px;
        ady = (py > last_y_reg) ? py - last_y_reg : last_y_reg - py;
        move_sum = DW'(adx) + DW'(ady);
    end

    // tracker update and result register
    always_comb
    begin
        last_x_next    = last_x_reg;
        last_y_next    = last_y_reg;
        touch_next     = touch_reg;
        moved          = 1'b0;
        out_valid_next = out_valid_reg && !m_tready;
        out_data_next  = out_data_reg;
        if (do_update)
        begin
            if (!span_ok_reg)
            begin
                touch_next = 1'b0;
            end
            else if (move_sum > DW'(MOVE_THRESHOLD))
            begin
                last_x_next = px;
                last_y_next = py;
                touch_next  = 1'b1;
                moved       = 1'b1;
            end
            out_valid_next = 1'b1;
            out_data_next  = OUT_W'({moved, last_y_next, last_x_next, touch_next});
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= BK_IDLE;
            step_reg      <= '0;
            last_x_reg    <= '0;
            last_y_reg    <= '0;
            touch_reg     <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            step_reg      <= step_next;
            last_x_reg    <= last_x_next;
            last_y_reg    <= last_y_next;
            touch_reg     <= touch_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (q_pop)
        begin
            dx_reg      <= q_data[ADC_BITS-1:0];
            sx_reg      <= q_data[2*ADC_BITS-1:ADC_BITS];
            dy_reg      <= q_data[3*ADC_BITS-1:2*ADC_BITS];
            sy_reg      <= q_data[4*ADC_BITS-1:3*ADC_BITS];
            span_ok_reg <= q_data[4*ADC_BITS];
        end
        remx_reg     <= remx_next;
        lox_reg      <= lox_next;
        remy_reg     <= remy_next;
        loy_reg      <= loy_next;
        out_data_reg <= out_data_next;
    end

endmodule

`default_nettype wire

// File: design/tatr_checker.sv
`timescale 1ns / 1ps
`default_nettype none

module tatr_checker
    import tatr_pkg::*;
#(
    parameter int COORD_BITS = DEF_COORD_BITS
)
(
    input wire logic                                   clk,
    input wire logic                                   rst_n,
    input wire logic                                   m_tvalid,
    input wire logic                                   m_tready,
    input wire logic [((2+2*COORD_BITS+7)/8)*8-1:0]    m_tdata
);

    localparam int PX_LO = 1;
    localparam int PY_LO = 1 + COORD_BITS;
    localparam int MV    = 1 + 2 * COORD_BITS;

    logic [COORD_BITS-1:0] pos_x;
    logic [COORD_BITS-1:0] pos_y;
    logic                  pressed;
    logic                  moved;
    logic                  xfer;
    logic [COORD_BITS-1:0] last_x_reg;
    logic [COORD_BITS-1:0] last_y_reg;

    assign pressed = m_tdata[0];
    assign pos_x   = m_tdata[PX_LO +: COORD_BITS];
    assign pos_y   = m_tdata[PY_LO +: COORD_BITS];
    assign moved   = m_tdata[MV];
    assign xfer    = m_tvalid && m_tready;

    // position of the previous result transfer
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            last_x_reg <= '0;
            last_y_reg <= '0;
        end
        else if (xfer)
        begin
            last_x_reg <= pos_x;
            last_y_reg <= pos_y;
        end
    end

    // a move is always reported as pressed
    a_moved_pressed: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && moved |-> pressed)
        else $error("moved result without pressed");

    // without a move the position holds
    a_hold_pos: assert property (@(posedge clk) disable iff (!rst_n)
        xfer && !moved |-> (pos_x == last_x_reg) && (pos_y == last_y_reg))
        else $error("position changed without moved");

    // a move changes the position
    a_move_changes: assert property (@(posedge clk) disable iff (!rst_n)
        xfer && moved |-> (pos_x != last_x_reg) || (pos_y != last_y_reg))
        else $error("moved result at the old position");

    // a stalled result holds
    a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result changed while stalled");

endmodule

bind touch_adc_to_screen_tracker_core tatr_checker #(
    .COORD_BITS (COORD_BITS)
) u_tatr_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);

`default_nettype wire
